// ===== design/assert_macros.svh =====
// assertion macros used by the parser rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define HRLP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// expression must never be true outside reset
`define HRLP_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define HRLP_ASSERT(lbl, clk, rstn, prop, msg)
`define HRLP_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

// ===== design/hrlp_pkg.sv =====
// shared types, constants and helper functions of the request line parser
package hrlp_pkg;

  // longest request line in bytes, terminator included
  localparam int LINE_LIMIT = 4096;
  localparam int OFS_W      = 12;
  localparam int LIM_W      = $clog2(LINE_LIMIT);
  localparam int CNT_W      = (LIM_W > OFS_W) ? LIM_W : OFS_W;

  // ascii codes
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_USCORE = 8'h5F;

  localparam logic [23:0] WORD_GET  = "GET";
  localparam logic [31:0] WORD_POST = "POST";
  localparam logic [31:0] WORD_HEAD = "HEAD";

  typedef enum logic [3:0] {
    PH_START      = 4'd0,
    PH_METHOD     = 4'd1,
    PH_SP_URI     = 4'd2,
    PH_URI        = 4'd3,
    PH_HTTP       = 4'd4,
    PH_H          = 4'd5,
    PH_HT         = 4'd6,
    PH_HTT        = 4'd7,
    PH_HTTP_SLASH = 4'd8,
    PH_MAJ1       = 4'd9,
    PH_MAJ        = 4'd10,
    PH_MIN1       = 4'd11,
    PH_MIN        = 4'd12,
    PH_SP_END     = 4'd13,
    PH_CR         = 4'd14
  } phase_e;

  typedef enum logic [1:0] {
    ST_MORE       = 2'd0,
    ST_DONE       = 2'd1,
    ST_BAD_METHOD = 2'd2,
    ST_BAD_REQ    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    METH_UNKNOWN = 2'd0,
    METH_GET     = 2'd1,
    METH_POST    = 2'd2,
    METH_HEAD    = 2'd3
  } method_e;

  // per-line parse state
  typedef struct packed {
    phase_e             phase;
    logic [CNT_W-1:0]   cnt;
    logic [31:0]        letters;
    method_e            method;
    logic [15:0]        major;
    logic [15:0]        minor;
    logic [OFS_W-1:0]   meth_term;
    logic [OFS_W-1:0]   uri_head;
    logic [OFS_W-1:0]   uri_end;
    logic [OFS_W-1:0]   line_end;
  } line_state_t;

  // one result transaction
  typedef struct packed {
    status_e            status;
    method_e            method;
    logic [15:0]        major;
    logic [15:0]        minor;
    logic [OFS_W-1:0]   meth_term;
    logic [OFS_W-1:0]   uri_head;
    logic [OFS_W-1:0]   uri_end;
    logic [OFS_W-1:0]   line_end;
  } result_t;

  function automatic logic is_method_char(input logic [7:0] c);
    return (c inside {[CH_A:CH_Z]}) || (c == CH_USCORE);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_0:CH_9]};
  endfunction

  // v*10 + digit, saturating at 16 bits; the low nibble of an ascii digit is its value
  function automatic logic [15:0] add_digit(input logic [15:0] v, input logic [7:0] c);
    logic [19:0] n;
    n = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {16'd0, c[3:0]};
    return (n > 20'd65535) ? 16'hFFFF : n[15:0];
  endfunction

endpackage

// ===== design/hrlp_in_stage.sv =====
// input register holding one accepted byte until the parse step takes it
module hrlp_in_stage
  import hrlp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       load;

  // hold off new bytes while the held one is not consumed
  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (load) begin
      valid_d = 1'b1;
      byte_d  = data_byte_i;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ===== design/hrlp_step.sv =====
// one parse step: next line state and result for a single byte
module hrlp_step
  import hrlp_pkg::*;
(
  input  line_state_t st_i,
  input  logic [7:0]  ch_i,
  output line_state_t nxt_o,
  output result_t     res_o
);

  line_state_t      nxt;
  status_e          status;
  logic             skip;
  logic             done;
  logic [OFS_W-1:0] pos;

  assign pos = st_i.cnt[OFS_W-1:0];

  always_comb begin
    nxt    = st_i;
    status = ST_MORE;
    skip   = 1'b0;
    done   = 1'b0;

    // phase transitions
    case (st_i.phase)
      PH_START: begin
        if (ch_i inside {CH_CR, CH_LF}) begin
          skip = 1'b1;
        end else if (!is_method_char(ch_i)) begin
          status = ST_BAD_METHOD;
        end else begin
          nxt.letters = {24'd0, ch_i};
          nxt.phase   = PH_METHOD;
        end
      end
      PH_METHOD: begin
        if (ch_i == CH_SPACE) begin
          nxt.meth_term = pos;
          nxt.method    = METH_UNKNOWN;
          if (st_i.cnt == CNT_W'(3) && st_i.letters[23:0] == WORD_GET) begin
            nxt.method = METH_GET;
          end else if (st_i.cnt == CNT_W'(4) && st_i.letters == WORD_POST) begin
            nxt.method = METH_POST;
          end else if (st_i.cnt == CNT_W'(4) && st_i.letters == WORD_HEAD) begin
            nxt.method = METH_HEAD;
          end
          nxt.phase = PH_SP_URI;
        end else if (!is_method_char(ch_i)) begin
          status = ST_BAD_METHOD;
        end else begin
          nxt.letters = {st_i.letters[23:0], ch_i};
        end
      end
      PH_SP_URI: begin
        if (ch_i == CH_SLASH) begin
          nxt.uri_head = pos;
          nxt.phase    = PH_URI;
        end else if (ch_i != CH_SPACE) begin
          status = ST_BAD_REQ;
        end
      end
      PH_URI: begin
        if (ch_i == CH_SPACE) begin
          nxt.uri_end = pos;
          nxt.phase   = PH_HTTP;
        end
      end
      PH_HTTP: begin
        if (ch_i == CH_H) begin
          nxt.phase = PH_H;
        end else if (ch_i != CH_SPACE) begin
          status = ST_BAD_REQ;
        end
      end
      PH_H: begin
        if (ch_i == CH_T) nxt.phase = PH_HT;
        else status = ST_BAD_REQ;
      end
      PH_HT: begin
        if (ch_i == CH_T) nxt.phase = PH_HTT;
        else status = ST_BAD_REQ;
      end
      PH_HTT: begin
        if (ch_i == CH_P) nxt.phase = PH_HTTP_SLASH;
        else status = ST_BAD_REQ;
      end
      PH_HTTP_SLASH: begin
        if (ch_i == CH_SLASH) nxt.phase = PH_MAJ1;
        else status = ST_BAD_REQ;
      end
      PH_MAJ1: begin
        if (ch_i inside {[CH_1:CH_9]}) begin
          nxt.major = {12'd0, ch_i[3:0]};
          nxt.phase = PH_MAJ;
        end else begin
          status = ST_BAD_REQ;
        end
      end
      PH_MAJ: begin
        if (ch_i == CH_DOT) begin
          nxt.phase = PH_MIN1;
        end else if (!is_digit(ch_i)) begin
          status = ST_BAD_REQ;
        end else begin
          nxt.major = add_digit(st_i.major, ch_i);
        end
      end
      PH_MIN1: begin
        if (is_digit(ch_i)) begin
          nxt.minor = {12'd0, ch_i[3:0]};
          nxt.phase = PH_MIN;
        end else begin
          status = ST_BAD_REQ;
        end
      end
      PH_MIN: begin
        if (ch_i == CH_CR) begin
          nxt.line_end = pos;
          nxt.phase    = PH_CR;
        end else if (ch_i == CH_LF) begin
          nxt.line_end = pos;
          done         = 1'b1;
        end else if (ch_i == CH_SPACE) begin
          nxt.phase = PH_SP_END;
        end else if (!is_digit(ch_i)) begin
          status = ST_BAD_REQ;
        end else begin
          nxt.minor = add_digit(st_i.minor, ch_i);
        end
      end
      PH_SP_END: begin
        if (ch_i == CH_CR) begin
          nxt.line_end = pos;
          nxt.phase    = PH_CR;
        end else if (ch_i == CH_LF) begin
          nxt.line_end = pos;
          done         = 1'b1;
        end else if (ch_i != CH_SPACE) begin
          status = ST_BAD_REQ;
        end
      end
      PH_CR: begin
        if (ch_i == CH_LF) done = 1'b1;
        else status = ST_BAD_REQ;
      end
      default: begin
        status = ST_BAD_REQ;
      end
    endcase

    // line finished, or too long without finishing
    if (done) begin
      status = ST_DONE;
    end else if (status == ST_MORE && !skip && st_i.cnt == CNT_W'(LINE_LIMIT - 1)) begin
      status = ST_BAD_REQ;
    end

    // result carries the fields after this byte
    res_o.status    = status;
    res_o.method    = nxt.method;
    res_o.major     = nxt.major;
    res_o.minor     = nxt.minor;
    res_o.meth_term = nxt.meth_term;
    res_o.uri_head  = nxt.uri_head;
    res_o.uri_end   = nxt.uri_end;
    res_o.line_end  = nxt.line_end;

    // clear the line after done or an error, else advance the offset unless the byte is skipped
    if (status != ST_MORE) begin
      nxt = '0;
    end else if (!skip) begin
      nxt.cnt = st_i.cnt + CNT_W'(1);
    end
    nxt_o = nxt;
  end

endmodule

// ===== design/hrlp_out_stage.sv =====
// result register with valid, held while the downstream stalls
module hrlp_out_stage
  import hrlp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  input  logic    out_stall_i,
  output logic    ready_o,
  output logic    out_valid_o,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q, res_d;

  // free when empty or being drained this cycle
  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== design/http_request_line_parser.sv =====
// top level of the byte-serial http request line parser
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------------
//  in      | input     | in_valid_i / in_stall_o   | data_byte_i
//  out     | output    | out_valid_o / out_stall_i | status, method code, version, offsets
//
// one byte is taken every cycle while the result register has room, and each gives one result transaction
// (input register, then the parse step into the result register).
// the line state sits in one register updated by the parse step, so byte n+1 sees
// the state left by byte n with no gap.
// reset puts the parser in its start phase with all line fields zero.
// a stall on the result channel holds the result register and then the input register.
`include "assert_macros.svh"
module http_request_line_parser
  import hrlp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       data_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       status_o,
  output logic [1:0]       method_code_o,
  output logic [15:0]      version_major_o,
  output logic [15:0]      version_minor_o,
  output logic [OFS_W-1:0] method_end_offset_o,
  output logic [OFS_W-1:0] uri_start_offset_o,
  output logic [OFS_W-1:0] uri_end_offset_o,
  output logic [OFS_W-1:0] line_end_offset_o
);

  logic        byte_vld;
  logic [7:0]  byte_val;
  logic        out_ready;
  logic        step_fire;
  line_state_t st_q, st_d, st_nxt;
  result_t     step_res;
  result_t     out_res;

  // input register
  hrlp_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .take_i      (step_fire),
    .valid_o     (byte_vld),
    .byte_o      (byte_val)
  );

  // parse step fires when a byte is held and the result register has room
  assign step_fire = byte_vld && out_ready;

  hrlp_step u_step (
    .st_i  (st_q),
    .ch_i  (byte_val),
    .nxt_o (st_nxt),
    .res_o (step_res)
  );

  // line state register
  assign st_d = step_fire ? st_nxt : st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  // result register
  hrlp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step_fire),
    .res_i       (step_res),
    .out_stall_i (out_stall_i),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign status_o            = out_res.status;
  assign method_code_o       = out_res.method;
  assign version_major_o     = out_res.major;
  assign version_minor_o     = out_res.minor;
  assign method_end_offset_o = out_res.meth_term;
  assign uri_start_offset_o  = out_res.uri_head;
  assign uri_end_offset_o    = out_res.uri_end;
  assign line_end_offset_o   = out_res.line_end;

  // checks
  `HRLP_ASSERT(a_start_clear, clk_i, rst_ni, (st_q.phase == PH_START) |-> (st_q.cnt == '0 && st_q.major == '0 && st_q.uri_end == '0), "start phase with stale line state")
  `HRLP_ASSERT(a_end_restart, clk_i, rst_ni, (step_fire && step_res.status != ST_MORE) |=> (st_q.phase == PH_START), "parser did not return to start after done or error")
  `HRLP_ASSERT(a_stall_held, clk_i, rst_ni, in_stall_o |-> byte_vld, "input stalled with empty input register")
  `HRLP_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_res)), "stalled result changed")

endmodule

// ===== verif/http_request_line_parser_checker.sv =====
// result checker for the http request line parser: predicts each result and compares it
module http_request_line_parser_checker
  import hrlp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [7:0]       data_byte_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [1:0]       status_i,
  input  logic [1:0]       method_code_i,
  input  logic [15:0]      version_major_i,
  input  logic [15:0]      version_minor_i,
  input  logic [OFS_W-1:0] method_end_offset_i,
  input  logic [OFS_W-1:0] uri_start_offset_i,
  input  logic [OFS_W-1:0] uri_end_offset_i,
  input  logic [OFS_W-1:0] line_end_offset_i,
  output int               mismatch_count_o,
  output int               pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // predicted line state
  phase_e           lp_phase;
  logic [OFS_W-1:0] lp_pos;
  int               lp_count;
  logic [31:0]      lp_letters;
  method_e          lp_method;
  logic [15:0]      lp_major;
  logic [15:0]      lp_minor;
  logic [OFS_W-1:0] lp_meth_end;
  logic [OFS_W-1:0] lp_uri_head;
  logic [OFS_W-1:0] lp_uri_end;
  logic [OFS_W-1:0] lp_line_end;

  // parse results still waiting for their output transaction
  result_t          parse_results_q[$];
  int               mismatches = 0;

  function automatic void clear_line_state();
    lp_phase     = PH_START;
    lp_pos       = '0;
    lp_count     = 0;
    lp_letters   = '0;
    lp_method    = METH_UNKNOWN;
    lp_major     = '0;
    lp_minor     = '0;
    lp_meth_end  = '0;
    lp_uri_head  = '0;
    lp_uri_end   = '0;
    lp_line_end  = '0;
  endfunction

  function automatic bit is_token_char(input logic [7:0] c);
    return (c >= CH_A && c <= CH_Z) || c == CH_USCORE;
  endfunction

  function automatic bit is_dec_char(input logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  // decimal accumulate, clamped at 16 bits
  function automatic logic [15:0] mul10_sat(input logic [15:0] v, input logic [7:0] c);
    int n;
    n = int'(v) * 10 + int'(c - CH_0);
    return (n > 65535) ? 16'hFFFF : 16'(n);
  endfunction

  // one byte through the line state machine
  task automatic parse_request_byte(input logic [7:0] ch, output result_t res);
    status_e st;
    bit      skip;
    bit      done;
    st   = ST_MORE;
    skip = 1'b0;
    done = 1'b0;
    case (lp_phase)
      PH_START: begin
        if (ch == CH_CR || ch == CH_LF) skip = 1'b1;
        else if (!is_token_char(ch)) st = ST_BAD_METHOD;
        else begin
          lp_letters = {24'd0, ch};
          lp_phase   = PH_METHOD;
        end
      end
      PH_METHOD: begin
        if (ch == CH_SPACE) begin
          lp_meth_end = lp_pos;
          lp_method   = METH_UNKNOWN;
          if (lp_count == 3 && lp_letters[23:0] == WORD_GET) lp_method = METH_GET;
          else if (lp_count == 4 && lp_letters == WORD_POST) lp_method = METH_POST;
          else if (lp_count == 4 && lp_letters == WORD_HEAD) lp_method = METH_HEAD;
          lp_phase = PH_SP_URI;
        end else if (!is_token_char(ch)) st = ST_BAD_METHOD;
        else lp_letters = {lp_letters[23:0], ch};
      end
      PH_SP_URI: begin
        if (ch == CH_SLASH) begin
          lp_uri_head = lp_pos;
          lp_phase    = PH_URI;
        end else if (ch != CH_SPACE) st = ST_BAD_REQ;
      end
      PH_URI: begin
        if (ch == CH_SPACE) begin
          lp_uri_end = lp_pos;
          lp_phase   = PH_HTTP;
        end
      end
      PH_HTTP: begin
        if (ch == CH_H) lp_phase = PH_H;
        else if (ch != CH_SPACE) st = ST_BAD_REQ;
      end
      PH_H: begin
        if (ch == CH_T) lp_phase = PH_HT;
        else st = ST_BAD_REQ;
      end
      PH_HT: begin
        if (ch == CH_T) lp_phase = PH_HTT;
        else st = ST_BAD_REQ;
      end
      PH_HTT: begin
        if (ch == CH_P) lp_phase = PH_HTTP_SLASH;
        else st = ST_BAD_REQ;
      end
      PH_HTTP_SLASH: begin
        if (ch == CH_SLASH) lp_phase = PH_MAJ1;
        else st = ST_BAD_REQ;
      end
      PH_MAJ1: begin
        if (ch < CH_1 || ch > CH_9) st = ST_BAD_REQ;
        else begin
          lp_major = 16'(ch - CH_0);
          lp_phase = PH_MAJ;
        end
      end
      PH_MAJ: begin
        if (ch == CH_DOT) lp_phase = PH_MIN1;
        else if (!is_dec_char(ch)) st = ST_BAD_REQ;
        else lp_major = mul10_sat(lp_major, ch);
      end
      PH_MIN1: begin
        if (!is_dec_char(ch)) st = ST_BAD_REQ;
        else begin
          lp_minor = 16'(ch - CH_0);
          lp_phase = PH_MIN;
        end
      end
      PH_MIN, PH_SP_END: begin
        if (ch == CH_CR) begin
          lp_line_end = lp_pos;
          lp_phase    = PH_CR;
        end else if (ch == CH_LF) begin
          lp_line_end = lp_pos;
          done        = 1'b1;
        end else if (ch == CH_SPACE) lp_phase = PH_SP_END;
        else if (lp_phase == PH_MIN && is_dec_char(ch)) lp_minor = mul10_sat(lp_minor, ch);
        else st = ST_BAD_REQ;
      end
      PH_CR: begin
        if (ch == CH_LF) done = 1'b1;
        else st = ST_BAD_REQ;
      end
      default: st = ST_BAD_REQ;
    endcase

    // line finished, or the byte limit reached without a finish
    if (done) st = ST_DONE;
    else if (st == ST_MORE && !skip && lp_count + 1 >= LINE_LIMIT) st = ST_BAD_REQ;

    res.status    = st;
    res.method    = lp_method;
    res.major     = lp_major;
    res.minor     = lp_minor;
    res.meth_term = lp_meth_end;
    res.uri_head  = lp_uri_head;
    res.uri_end   = lp_uri_end;
    res.line_end  = lp_line_end;

    if (st != ST_MORE) clear_line_state();
    else if (!skip) begin
      lp_count++;
      lp_pos = lp_pos + 1'b1;
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) $display("[%0t] parser result: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, predicted %0h", name, got, want));
  endtask

  // predict on every byte transaction, compare on every result transaction
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      clear_line_state();
      parse_results_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        parse_request_byte(data_byte_i, want);
        parse_results_q.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        if (parse_results_q.size() == 0) report_mismatch("result with no byte outstanding");
        else begin
          want = parse_results_q.pop_front();
          check_field("status", 16'(status_i), 16'(want.status));
          check_field("method_code", 16'(method_code_i), 16'(want.method));
          check_field("version_major", version_major_i, want.major);
          check_field("version_minor", version_minor_i, want.minor);
          check_field("method_end_offset", 16'(method_end_offset_i), 16'(want.meth_term));
          check_field("uri_start_offset", 16'(uri_start_offset_i), 16'(want.uri_head));
          check_field("uri_end_offset", 16'(uri_end_offset_i), 16'(want.uri_end));
          check_field("line_end_offset", 16'(line_end_offset_i), 16'(want.line_end));
        end
      end
    end
    mismatch_count_o = mismatches;
    pending_count_o  = parse_results_q.size();
  end

endmodule

// ===== verif/tb_http_request_line_parser.sv =====
// testbench top for the http request line parser: byte stimulus, stalls and verdict
module tb_http_request_line_parser;
  import hrlp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 40000;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [7:0]       data_byte_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [1:0]       status_o;
  logic [1:0]       method_code_o;
  logic [15:0]      version_major_o;
  logic [15:0]      version_minor_o;
  logic [OFS_W-1:0] method_end_offset_o;
  logic [OFS_W-1:0] uri_start_offset_o;
  logic [OFS_W-1:0] uri_end_offset_o;
  logic [OFS_W-1:0] line_end_offset_o;

  int               mismatch_count;
  int               pending_count;
  int               cycle_cnt;

  // every byte to be sent, in order
  logic [7:0]       req_bytes[$];
  string            near_miss[7] = '{"GEX", "GETS", "POS", "HEAX", "POSTT", "_ET", "G"};

  http_request_line_parser dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .data_byte_i         (data_byte_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_o            (status_o),
    .method_code_o       (method_code_o),
    .version_major_o     (version_major_o),
    .version_minor_o     (version_minor_o),
    .method_end_offset_o (method_end_offset_o),
    .uri_start_offset_o  (uri_start_offset_o),
    .uri_end_offset_o    (uri_end_offset_o),
    .line_end_offset_o   (line_end_offset_o)
  );

  http_request_line_parser_checker result_check (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_i          (in_stall_o),
    .data_byte_i         (data_byte_i),
    .out_valid_i         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_i            (status_o),
    .method_code_i       (method_code_o),
    .version_major_i     (version_major_o),
    .version_minor_i     (version_minor_o),
    .method_end_offset_i (method_end_offset_o),
    .uri_start_offset_i  (uri_start_offset_o),
    .uri_end_offset_i    (uri_end_offset_o),
    .line_end_offset_i   (line_end_offset_o),
    .mismatch_count_o    (mismatch_count),
    .pending_count_o     (pending_count)
  );

  always #2 clk_i = ~clk_i;

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
  endfunction

  function automatic void push_spaces(input int n);
    for (int i = 0; i < n; i++) req_bytes.push_back(CH_SPACE);
  endfunction

  function automatic void push_digits(input int n);
    for (int i = 0; i < n; i++) req_bytes.push_back(8'(CH_0 + $urandom_range(0, 9)));
  endfunction

  function automatic logic [7:0] rand_token_byte();
    int k;
    k = $urandom_range(0, 26);
    return (k == 26) ? CH_USCORE : 8'(CH_A + k);
  endfunction

  // anything but a space is uri content
  function automatic logic [7:0] rand_uri_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_SPACE);
    return b;
  endfunction

  // well-formed request line with random content, optionally with one byte corrupted
  function automatic void push_random_request(input bit broken);
    int first;
    int n;
    first = req_bytes.size();
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    for (int i = 0; i < n; i++) req_bytes.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
    case ($urandom_range(0, 5))
      0: push_text("GET");
      1: push_text("POST");
      2: push_text("HEAD");
      3: push_text(near_miss[$urandom_range(0, 6)]);
      default: begin
        n = $urandom_range(1, 7);
        for (int i = 0; i < n; i++) req_bytes.push_back(rand_token_byte());
      end
    endcase
    push_spaces($urandom_range(1, 3));
    req_bytes.push_back(CH_SLASH);
    n = $urandom_range(0, 10);
    for (int i = 0; i < n; i++) req_bytes.push_back(rand_uri_byte());
    push_spaces($urandom_range(1, 2));
    push_text("HTTP/");
    req_bytes.push_back(8'(CH_1 + $urandom_range(0, 8)));
    push_digits(($urandom_range(0, 7) == 0) ? 5 : $urandom_range(0, 2));
    req_bytes.push_back(CH_DOT);
    push_digits(($urandom_range(0, 7) == 0) ? 6 : $urandom_range(1, 3));
    if ($urandom_range(0, 2) == 0) push_spaces($urandom_range(1, 2));
    if ($urandom_range(0, 1)) req_bytes.push_back(CH_CR);
    req_bytes.push_back(CH_LF);
    if (broken) req_bytes[$urandom_range(first, req_bytes.size() - 1)] = 8'($urandom);
  endfunction

  // stimulus, reset, byte transactions and verdict
  initial begin
    int first;
    int k;
    int taken;
    int gap_left;
    int burst_left;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = 8'd0;

    // directed lines: methods, skips, error paths, saturation
    push_text("\015\n\015GET / HTTP/1.1\015\n");
    push_text("POST /index.html HTTP/1.0\n");
    push_text("HEAD   /x  HTTP/9.9  \015\n");
    push_text("GETX /a HTTP/2.0\n");
    push_text("GEX /a HTTP/1.1\015\n");
    push_text("A_Z /_ HTTP/1.1\n");
    push_text("get / HTTP/1.1\n");
    push_text("GE1\n");
    push_text("GET x\n");
    push_text("GET / XYZ\n");
    push_text("GET / HTTX\n");
    push_text("GET / HTTP/0.1\n");
    push_text("GET / HTTP/1.x\n");
    push_text("GET / HTTP/1.1\015X\n");
    push_text("GET / HTTP/1.1 x\n");
    push_text("GET / HTTP/99999999.70000\015\n");
    push_text("GET /\015\n HTTP/12a\n");
    push_text("POST / HTTP/1.\n");
    push_text("GET /  HTTP/1.1 \n");

    // random part: mostly well-formed lines, some corrupted lines and noise
    first = req_bytes.size();
    while (req_bytes.size() - first < 100) begin
      k = $urandom_range(0, 9);
      if (k < 7) push_random_request(1'b0);
      else if (k < 9) push_random_request(1'b1);
      else begin
        repeat ($urandom_range(1, 6)) req_bytes.push_back(8'($urandom));
        req_bytes.push_back(CH_LF);
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // byte transactions in bursts with random gaps
    taken      = 0;
    gap_left   = 0;
    burst_left = $urandom_range(1, 40);
    while (taken < req_bytes.size()) begin
      @(posedge clk_i);
      if (in_valid_i && !in_stall_o) taken++;
      if (taken == req_bytes.size()) in_valid_i <= 1'b0;
      else if (!(in_valid_i && in_stall_o)) begin
        if (gap_left > 0) begin
          in_valid_i <= 1'b0;
          gap_left--;
        end else begin
          in_valid_i  <= 1'b1;
          data_byte_i <= req_bytes[taken];
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 60);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end

    // drain outstanding results, then let the pipeline settle
    do @(negedge clk_i); while (pending_count != 0);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("http_request_line_parser: match");
    end else begin
      $display("http_request_line_parser: mismatch");
    end
    $finish;
  end

  // result side stalls in segments of random density, with one long hold-off
  initial begin
    int seg_len;
    int stall_pct;
    int seg_idx;
    int k;
    out_stall_i = 1'b0;
    seg_idx     = 0;
    wait (rst_ni);
    forever begin
      seg_len = $urandom_range(10, 80);
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 30;
        default: stall_pct = 75;
      endcase
      for (k = 0; k < seg_len; k++) begin
        @(posedge clk_i);
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
      seg_idx++;
      // long hold-off so the parser fills up and stalls its byte input
      if (seg_idx == 2) begin
        @(posedge clk_i);
        out_stall_i <= 1'b1;
        for (k = 0; k < 400; k++) @(posedge clk_i);
      end
    end
  end

  // watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("http_request_line_parser: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/hrlp_pkg.sv
design/hrlp_in_stage.sv
design/hrlp_step.sv
design/hrlp_out_stage.sv
design/http_request_line_parser.sv
verif/http_request_line_parser_checker.sv
verif/tb_http_request_line_parser.sv
